// ===== sv/base64_stream_decoder_top_macros.svh =====
// Assertion helpers shared by the decoder RTL.
`ifndef BASE64_STREAM_DECODER_TOP_MACROS_SVH
`define BASE64_STREAM_DECODER_TOP_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define B64D_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked in the cycle after the trigger.
`define B64D_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== sv/b64d_pkg.sv =====
`default_nettype none

package b64d_pkg;

    // Item opcodes and result codes.
    localparam logic OP_CHAR     = 1'b0;
    localparam logic OP_END      = 1'b1;
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_END    = 1'b1;
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_BAD  = 1'b1;

    // Characters with special handling.
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_EQ    = 8'h3D;

    localparam logic [6:0] PAD_CODE = 7'h7F;
    localparam logic [7:0] NO_CODE  = 8'hFF;

    localparam int          QUEUE_DEPTH = 4;
    localparam int          QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam logic [1:0]  LAST_IDX_1  = 2'd0;
    localparam logic [1:0]  LAST_IDX_2  = 2'd1;
    localparam logic [1:0]  LAST_IDX_3  = 2'd2;

    // One queued job: a data group (1..3 bytes) or an end-of-stream status.
    typedef struct packed {
        logic            is_end;
        logic            status;
        logic [1:0]      last_idx;
        logic [2:0][7:0] bytes;
    } job_t;

    // Queue flags passed to the front and back ends.
    typedef struct packed {
        logic empty;
        logic full;
    } q_flags_t;

    // 7-bit character to 6-bit code, PAD_CODE, or NO_CODE.
    function automatic logic [7:0] b64_lookup(input logic [6:0] c);
        logic [7:0] r;
        r = NO_CODE;
        if (c >= 7'h41 && c <= 7'h5A)
            r = {1'b0, 7'(c - 7'h41)};
        else if (c >= 7'h61 && c <= 7'h7A)
            r = {1'b0, 7'(c - 7'h61 + 7'd26)};
        else if (c >= 7'h30 && c <= 7'h39)
            r = {1'b0, 7'(c - 7'h30 + 7'd52)};
        else if (c == CH_PLUS[6:0])
            r = 8'h3E;
        else if (c == CH_SLASH[6:0])
            r = 8'h3F;
        else if (c == CH_EQ[6:0])
            r = {1'b0, PAD_CODE};
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/b64d_stream_if.sv =====
`default_nettype none

// Character input channel.
interface b64d_in_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] char_in;

    modport source (output valid, output op, output char_in, input ready);
    modport sink   (input valid, input op, input char_in, output ready);
endinterface

// Result output channel.
interface b64d_out_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] byte_out;
    logic       status;
    logic       last;

    modport source (output valid, output kind, output byte_out, output status,
                    output last, input ready);
    modport sink   (input valid, input kind, input byte_out, input status,
                    input last, output ready);
endinterface

`default_nettype wire

// ===== sv/b64d_front.sv =====
`default_nettype none

module b64d_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic              cfg_wdata,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              in_op,
    input  wire logic [7:0]        in_char,
    input  wire b64d_pkg::q_flags_t q_flags,
    output logic                   push,
    output b64d_pkg::job_t         push_job
);
    import b64d_pkg::*;

    logic            alt_alpha_reg;
    logic [2:0][6:0] codes_reg, codes_next;
    logic [1:0]      count_reg, count_next;
    logic            failed_reg, failed_next;

    logic            accept;
    logic [7:0]      ch;
    logic [7:0]      code;
    logic [6:0]      c3;
    logic            bad_pad;

    assign in_ready = !q_flags.full;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        ch = in_char;
        if (alt_alpha_reg && in_char == CH_DASH)
            ch = CH_PLUS;
        else if (alt_alpha_reg && in_char == CH_UNDER)
            ch = CH_SLASH;
    end

    assign code    = b64_lookup(ch[6:0]);
    assign c3      = code[6:0];
    assign bad_pad = (codes_reg[0] == PAD_CODE) || (codes_reg[1] == PAD_CODE) ||
                     (codes_reg[2] == PAD_CODE && c3 != PAD_CODE);

    always_comb
    begin
        codes_next  = codes_reg;
        count_next  = count_reg;
        failed_next = failed_reg;
        push        = 1'b0;
        push_job    = '0;
        if (accept)
        begin
            if (in_op == OP_END)
            begin
                push            = 1'b1;
                push_job.is_end = 1'b1;
                push_job.status = (failed_reg || count_reg != 2'd0) ? STATUS_BAD
                                                                    : STATUS_OK;
                push_job.last_idx = LAST_IDX_1;
                codes_next  = '0;
                count_next  = 2'd0;
                failed_next = 1'b0;
            end
            else if (!ch[7] && !failed_reg && code != NO_CODE)
            begin
                if (count_reg != 2'd3)
                begin
                    codes_next[count_reg] = c3;
                    count_next = 2'(count_reg + 2'd1);
                end
                else
                begin
                    codes_next = '0;
                    count_next = 2'd0;
                    if (bad_pad)
                        failed_next = 1'b1;
                    else
                    begin
                        push = 1'b1;
                        push_job.status   = STATUS_OK;
                        push_job.bytes[0] = {codes_reg[0][5:0], codes_reg[1][5:4]};
                        push_job.bytes[1] = {codes_reg[1][3:0], codes_reg[2][5:2]};
                        push_job.bytes[2] = {codes_reg[2][1:0], c3[5:0]};
                        if (codes_reg[2] == PAD_CODE)
                            push_job.last_idx = LAST_IDX_1;
                        else if (c3 == PAD_CODE)
                            push_job.last_idx = LAST_IDX_2;
                        else
                            push_job.last_idx = LAST_IDX_3;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alt_alpha_reg <= 1'b0;
            codes_reg     <= '0;
            count_reg     <= 2'd0;
            failed_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                alt_alpha_reg <= cfg_wdata;
            codes_reg  <= codes_next;
            count_reg  <= count_next;
            failed_reg <= failed_next;
        end
    end

`include "base64_stream_decoder_top_macros.svh"

    `B64D_ASSERT_NEXT(a_end_clears, accept && in_op == OP_END, count_reg == 2'd0 && !failed_reg, "end item did not clear group state")
    `B64D_ASSERT_ALWAYS(a_no_push_failed, !(push && !push_job.is_end && failed_reg), "data job pushed after failure")

endmodule

`default_nettype wire

// ===== sv/b64d_queue.sv =====
`default_nettype none

module b64d_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire b64d_pkg::job_t     push_job,
    input  wire logic               pop,
    output b64d_pkg::job_t          head_job,
    output b64d_pkg::q_flags_t      flags
);
    import b64d_pkg::*;

    job_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg, count_next;

    assign flags.empty = (count_reg == '0);
    assign flags.full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign head_job    = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

`include "base64_stream_decoder_top_macros.svh"

    `B64D_ASSERT_ALWAYS(a_no_overflow, !(push && flags.full), "push into full queue")
    `B64D_ASSERT_ALWAYS(a_no_underflow, !(pop && flags.empty), "pop from empty queue")

endmodule

`default_nettype wire

// ===== sv/b64d_back.sv =====
`default_nettype none

module b64d_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire b64d_pkg::job_t     head_job,
    input  wire b64d_pkg::q_flags_t q_flags,
    output logic                    pop,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    out_kind,
    output logic [7:0]              out_byte,
    output logic                    out_status,
    output logic                    out_last
);
    import b64d_pkg::*;

    job_t       job_reg;
    logic       job_valid_reg;
    logic [1:0] idx_reg;

    logic       out_valid_reg;
    logic       kind_reg;
    logic [7:0] byte_reg;
    logic       status_reg;
    logic       last_reg;

    logic       load;
    logic       word_last;
    logic [7:0] word_byte;

    assign load      = job_valid_reg && (!out_valid_reg || out_ready);
    assign word_last = job_reg.is_end || (idx_reg == job_reg.last_idx);
    assign pop       = !q_flags.empty && (!job_valid_reg || (load && word_last));

    always_comb
    begin
        case (idx_reg)
            2'd0:    word_byte = job_reg.bytes[0];
            2'd1:    word_byte = job_reg.bytes[1];
            default: word_byte = job_reg.bytes[2];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                job_valid_reg <= 1'b1;
                idx_reg       <= 2'd0;
            end
            else if (load && word_last)
                job_valid_reg <= 1'b0;
            else if (load)
                idx_reg <= idx_reg + 2'd1;

            if (load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            job_reg <= head_job;
        if (load)
        begin
            kind_reg   <= job_reg.is_end ? KIND_END : KIND_DATA;
            byte_reg   <= job_reg.is_end ? 8'h00 : word_byte;
            status_reg <= job_reg.is_end ? job_reg.status : STATUS_OK;
            last_reg   <= word_last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_kind   = kind_reg;
    assign out_byte   = byte_reg;
    assign out_status = status_reg;
    assign out_last   = last_reg;

`include "base64_stream_decoder_top_macros.svh"

    `B64D_ASSERT_ALWAYS(a_end_is_last, !(out_valid_reg && kind_reg == KIND_END && !last_reg), "end status word without last")

endmodule

`default_nettype wire

// ===== sv/base64_stream_decoder_top.sv =====
// Streaming base64 decoder (standard or url-safe alphabet).
// in_ch  : one word per character, op selects character or end of stream.
// out_ch : decoded bytes (kind data), then one status word (kind end) per
//          end of stream; last marks the final word caused by one input word.
// cfg_we / cfg_wdata: url-safe alphabet select, written while idle.
// Throughput: one input word per cycle while the job queue is not full;
//             one output word per cycle while the receiver is ready.
// Path: the front classifies and gathers codes in the accept cycle and
//       pushes a job into a 4-entry job queue, which feeds the back end;
//       the back end serializes each job into output words.
// A four-character group yields at most 3 bytes, so the back end keeps up
// with one character per cycle.
// Receiver stall: the output register holds its word, the back end stops,
// the job queue fills and then in_ch.ready drops.
// Reset: clears the group, the failure flag, the queue and url-safe mode.
// After a format error no more bytes come out until the end word, whose
// status reports invalid; bytes given earlier in that stream are suspect.
`default_nettype none

module base64_stream_decoder_top (
    input  wire logic  clk,
    input  wire logic  rst_n,
    b64d_in_if.sink    in_ch,
    b64d_out_if.source out_ch,
    input  wire logic  cfg_we,
    input  wire logic  cfg_wdata
);
    import b64d_pkg::*;

    // front -> queue
    logic     push;
    job_t     push_job;
    // queue -> back
    logic     pop;
    job_t     head_job;
    q_flags_t q_flags;

    // Front: lookup, padding checks, group gathering, sticky failure.
    b64d_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .in_op     (in_ch.op),
        .in_char   (in_ch.char_in),
        .q_flags   (q_flags),
        .push      (push),
        .push_job  (push_job)
    );

    // Job queue decouples character intake from byte output.
    b64d_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .flags    (q_flags)
    );

    // Back: serializes each job into output words.
    b64d_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_job   (head_job),
        .q_flags    (q_flags),
        .pop        (pop),
        .out_valid  (out_ch.valid),
        .out_ready  (out_ch.ready),
        .out_kind   (out_ch.kind),
        .out_byte   (out_ch.byte_out),
        .out_status (out_ch.status),
        .out_last   (out_ch.last)
    );

endmodule

`default_nettype wire

// ===== verif/base64_stream_decoder_top_tb.sv =====
`timescale 1ns / 100ps

module base64_stream_decoder_top_tb;

    import b64d_pkg::*;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 5;
    localparam int MAX_GAP      = 13;
    localparam int SETTLE       = 8;       // idle cycles before a cfg write
    localparam int TAIL_CYCLES  = 20;      // drain time once nothing is due
    localparam int HOLD_CYCLES  = 400;     // long receiver hold-off
    localparam int RAND_WORDS   = 350;
    localparam int PHASE_WORDS  = 60;
    localparam int BURST_WORDS  = 80;
    localparam int CYCLE_LIMIT  = 200000;
    localparam logic [7:0] PAD8 = {1'b0, PAD_CODE};

    // What the driver does with the entry at the head of its queue.
    typedef enum logic [1:0] {ACT_WORD, ACT_CFG, ACT_DRAIN} act_t;

    typedef struct {
        act_t       act;
        logic       op;
        logic [7:0] ch;
        int         gap;      // idle cycles before the word is offered
        logic       cfg_val;
    } char_item_t;

    // One output word as the decoder should give it.
    typedef struct packed {
        logic       kind;
        logic [7:0] byte_val;
        logic       status;
        logic       last;
    } dec_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we;
    logic cfg_wdata;

    b64d_in_if  in_if();
    b64d_out_if out_if();

    base64_stream_decoder_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_if),
        .out_ch    (out_if),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #CLK_HALF clk = ~clk;

    // Pending character words and the decoded words still owed by the DUT.
    char_item_t char_q[$];
    dec_word_t  decoded_q[$];

    // Decoder shadow state, updated as words are accepted.
    logic [6:0] grp [0:2];
    int         grp_cnt  = 0;
    logic       grp_fail = 1'b0;
    logic       url_mode = 1'b0;

    int   mismatches = 0;
    int   words_in   = 0;
    int   words_out  = 0;
    int   cycles     = 0;

    // Stimulus build state.
    int   gap_max     = MAX_GAP;
    int   words_total = 0;
    int   counted     = 0;
    logic build_url   = 1'b0;
    int   burst_at    = 32'h7fffffff;

    // Receiver control.
    logic rx_hold  = 1'b0;
    int   rx_mode  = 1;
    int   stall_cnt = 0;

    // Driver scratch.
    char_item_t cur;
    int   gap_cnt    = 0;
    int   settle_cnt = 0;
    logic nxt_valid;
    logic nxt_we;

    //------------------------------------------------------------------
    // Character classification: 6-bit code, PAD8 for '=', NO_CODE if the
    // character is skipped (high half, or outside the alphabet).
    //------------------------------------------------------------------
    function automatic logic [7:0] char_to_code(input logic [7:0] ch, input logic url);
        logic [7:0] c;
        c = ch;
        if (c[7])
            return NO_CODE;
        if (url && c == CH_DASH)
            c = CH_PLUS;
        else if (url && c == CH_UNDER)
            c = CH_SLASH;
        if (c >= "A" && c <= "Z")
            return c - "A";
        if (c >= "a" && c <= "z")
            return c - "a" + 8'd26;
        if (c >= "0" && c <= "9")
            return c - "0" + 8'd52;
        if (c == CH_PLUS)
            return 8'h3E;
        if (c == CH_SLASH)
            return 8'h3F;
        if (c == CH_EQ)
            return PAD8;
        return NO_CODE;
    endfunction

    task automatic push_decoded(input logic kind, input logic [7:0] b, input logic st,
                                input logic last);
        dec_word_t w;
        w.kind     = kind;
        w.byte_val = b;
        w.status   = st;
        w.last     = last;
        decoded_q.push_back(w);
    endtask

    // Shadow decode of one accepted input word.
    task automatic decode_char(input logic op, input logic [7:0] ch);
        logic [7:0] code;
        logic [7:0] c0, c1, c2, c3;
        if (op == OP_END) begin
            push_decoded(KIND_END, 8'h00,
                         (grp_fail || grp_cnt != 0) ? STATUS_BAD : STATUS_OK, 1'b1);
            grp_cnt  = 0;
            grp_fail = 1'b0;
            grp[0] = '0;
            grp[1] = '0;
            grp[2] = '0;
        end
        else begin
            code = char_to_code(ch, url_mode);
            if (!grp_fail && code != NO_CODE) begin
                if (grp_cnt < 3) begin
                    grp[grp_cnt] = code[6:0];
                    grp_cnt++;
                end
                else begin
                    c0 = {1'b0, grp[0]};
                    c1 = {1'b0, grp[1]};
                    c2 = {1'b0, grp[2]};
                    c3 = code;
                    grp_cnt = 0;
                    grp[0] = '0;
                    grp[1] = '0;
                    grp[2] = '0;
                    if (c0 == PAD8 || c1 == PAD8 || (c2 == PAD8 && c3 != PAD8))
                        grp_fail = 1'b1;
                    else if (c2 == PAD8)
                        push_decoded(KIND_DATA, (c0 << 2) | (c1 >> 4), STATUS_OK, 1'b1);
                    else if (c3 == PAD8) begin
                        push_decoded(KIND_DATA, (c0 << 2) | (c1 >> 4), STATUS_OK, 1'b0);
                        push_decoded(KIND_DATA, (c1 << 4) | (c2 >> 2), STATUS_OK, 1'b1);
                    end
                    else begin
                        push_decoded(KIND_DATA, (c0 << 2) | (c1 >> 4), STATUS_OK, 1'b0);
                        push_decoded(KIND_DATA, (c1 << 4) | (c2 >> 2), STATUS_OK, 1'b0);
                        push_decoded(KIND_DATA, (c2 << 6) | c3, STATUS_OK, 1'b1);
                    end
                end
            end
        end
    endtask

    //------------------------------------------------------------------
    // Stimulus builders. Only the initial block calls these, at time 0.
    //------------------------------------------------------------------
    function automatic int draw_gap();
        return (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
    endfunction

    task automatic push_word(input logic op, input logic [7:0] ch);
        char_item_t it;
        it.act     = ACT_WORD;
        it.op      = op;
        it.ch      = ch;
        it.gap     = draw_gap();
        it.cfg_val = 1'b0;
        char_q.push_back(it);
        words_total++;
        counted++;
    endtask

    task automatic push_end();
        push_word(OP_END, 8'($urandom_range(0, 255)));
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_word(OP_CHAR, s[i]);
    endtask

    // Wait for the DUT to go quiet, then write the alphabet select.
    task automatic push_cfg(input logic v);
        char_item_t it;
        it.act     = ACT_DRAIN;
        it.op      = OP_CHAR;
        it.ch      = 8'h00;
        it.gap     = 0;
        it.cfg_val = 1'b0;
        char_q.push_back(it);
        it.act     = ACT_CFG;
        it.cfg_val = v;
        char_q.push_back(it);
        build_url  = v;
    endtask

    function automatic logic [7:0] code_to_char(input int code);
        if (code < 26)
            return 8'("A" + code);
        if (code < 52)
            return 8'("a" + code - 26);
        if (code < 62)
            return 8'("0" + code - 52);
        // Url mode accepts both alphabets.
        if (code == 62)
            return (build_url && $urandom_range(0, 1)) ? CH_DASH : CH_PLUS;
        return (build_url && $urandom_range(0, 1)) ? CH_UNDER : CH_SLASH;
    endfunction

    function automatic logic [7:0] skip_char();
        case ($urandom_range(0, 5))
            0: return 8'($urandom_range(128, 255));
            1: return 8'h00;
            2: return 8'h7F;
            3: return " ";
            4: return build_url ? "." : ($urandom_range(0, 1) ? CH_DASH : CH_UNDER);
            default: return "*";
        endcase
    endfunction

    task automatic push_code(input int code);
        if ($urandom_range(0, 7) == 0)
            push_word(OP_CHAR, skip_char());
        push_word(OP_CHAR, code_to_char(code));
    endtask

    // Well-formed stream with random content; now and then a partial group.
    task automatic push_good_stream();
        int ngrp;
        int tail;
        ngrp = $urandom_range(0, 4);
        for (int g = 0; g < ngrp; g++)
            for (int k = 0; k < 4; k++)
                push_code($urandom_range(0, 63));
        tail = $urandom_range(0, 2);
        if (tail != 0) begin
            push_code($urandom_range(0, 63));
            push_code($urandom_range(0, 63));
            if (tail == 2)
                push_code($urandom_range(0, 63));
            else
                push_word(OP_CHAR, CH_EQ);
            push_word(OP_CHAR, CH_EQ);
            // data after a padded group still decodes
            if ($urandom_range(0, 3) == 0)
                for (int k = 0; k < 4; k++)
                    push_code($urandom_range(0, 63));
        end
        if ($urandom_range(0, 7) == 0)
            for (int k = $urandom_range(1, 3); k > 0; k--)
                push_code($urandom_range(0, 63));
        push_end();
    endtask

    // Noise and broken padding.
    task automatic push_noise_stream();
        for (int n = $urandom_range(1, 10); n > 0; n--)
            case ($urandom_range(0, 5)) inside
                0, 1, 5: push_word(OP_CHAR, code_to_char($urandom_range(0, 63)));
                2:       push_word(OP_CHAR, CH_EQ);
                3:       push_word(OP_CHAR, 8'($urandom_range(0, 255)));
                default: push_word(OP_CHAR, skip_char());
            endcase
        push_end();
    endtask

    //------------------------------------------------------------------
    // Driver: offers the head of char_q, handles drain and cfg entries.
    // Every accepted word goes through the shadow decoder at the same edge.
    //------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            in_if.valid <= 1'b0;
            cfg_we      <= 1'b0;
            gap_cnt     = 0;
            settle_cnt  = 0;
        end
        else begin
            nxt_valid = 1'b0;
            nxt_we    = 1'b0;
            if (in_if.valid && in_if.ready) begin
                decode_char(in_if.op, in_if.char_in);
                void'(char_q.pop_front());
                words_in++;
                gap_cnt = 0;
            end
            if (char_q.size() != 0) begin
                cur = char_q[0];
                case (cur.act)
                    ACT_WORD:
                        if (gap_cnt >= cur.gap) begin
                            nxt_valid = 1'b1;
                            in_if.op      <= cur.op;
                            in_if.char_in <= cur.ch;
                        end
                        else
                            gap_cnt++;
                    ACT_DRAIN:
                        // wait until nothing is owed and the settle count reaches SETTLE
                        if (decoded_q.size() != 0)
                            settle_cnt = 0;
                        else if (settle_cnt >= SETTLE) begin
                            settle_cnt = 0;
                            void'(char_q.pop_front());
                        end
                        else
                            settle_cnt++;
                    ACT_CFG:
                        begin
                            nxt_we = 1'b1;
                            cfg_wdata <= cur.cfg_val;
                            url_mode = cur.cfg_val;
                            void'(char_q.pop_front());
                        end
                    default: ;
                endcase
            end
            in_if.valid <= nxt_valid;
            cfg_we      <= nxt_we;
        end
    end

    //------------------------------------------------------------------
    // Monitor: random ready with per-word stalls, field-by-field compare
    // against the oldest owed word.
    //------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin
        dec_word_t want;
        dec_word_t got;
        if (!rst_n) begin
            out_if.ready <= 1'b0;
            stall_cnt = 0;
        end
        else begin
            if (out_if.valid && out_if.ready) begin
                got.kind     = out_if.kind;
                got.byte_val = out_if.byte_out;
                got.status   = out_if.status;
                got.last     = out_if.last;
                if (decoded_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected word kind=%0b byte=%02h status=%0b last=%0b",
                                 $realtime, got.kind, got.byte_val, got.status, got.last);
                end
                else begin
                    want = decoded_q.pop_front();
                    if (got.kind !== want.kind || got.byte_val !== want.byte_val ||
                        got.status !== want.status || got.last !== want.last) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: mismatch exp kind=%0b byte=%02h status=%0b last=%0b, got kind=%0b byte=%02h status=%0b last=%0b",
                                     $realtime, want.kind, want.byte_val, want.status,
                                     want.last, got.kind, got.byte_val, got.status, got.last);
                    end
                end
                words_out++;
                // stretches: no stalls, long stalls, short stalls
                if (words_out % 40 == 0)
                    rx_mode = $urandom_range(0, 2);
                stall_cnt = (rx_mode == 0) ? 0 :
                            (rx_mode == 1) ? $urandom_range(0, MAX_GAP) : $urandom_range(0, 3);
            end
            else if (stall_cnt != 0)
                stall_cnt--;
            out_if.ready <= (stall_cnt == 0) && !rx_hold;
        end
    end

    // Long receiver hold-off while the burst phase keeps the input busy:
    // the job queue fills and in_ch.ready must drop.
    initial begin
        while (words_in < burst_at)
            @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    // Watchdog.
    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    //------------------------------------------------------------------
    // Stimulus, reset and end of run.
    //------------------------------------------------------------------
    initial begin
        in_if.valid   = 1'b0;
        in_if.op      = OP_CHAR;
        in_if.char_in = 8'h00;
        out_if.ready  = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = 1'b0;
        grp[0] = '0;
        grp[1] = '0;
        grp[2] = '0;

        // Directed, standard alphabet (reset value).
        // Full group with a high-half skip inside, pad-then-data, all-zero group.
        push_text("TW");
        push_word(OP_CHAR, 8'h80);
        push_text("FuQQ==");
        push_word(OP_CHAR, 8'hFF);
        push_text("AAAA");
        push_end();
        // all-ones bytes, two-byte tail; '-' is not in the standard alphabet
        push_text("//8=-");
        push_end();
        // pad only at position 2: stream fails, later chars are dropped
        push_text("AB=Cx");
        push_end();
        // partial group at the end
        push_text("AB");
        push_end();
        // url-safe alphabet, both spellings of codes 62 and 63
        push_cfg(1'b1);
        push_text("-_+/");
        push_end();

        // Random phases, alternating the alphabet.
        while (counted < RAND_WORDS) begin
            if (counted / PHASE_WORDS % 2 != build_url)
                push_cfg(!build_url);
            if (burst_at == 32'h7fffffff && counted >= 120) begin
                // Burst with no sender gaps while the receiver holds off.
                push_cfg(build_url);
                burst_at = words_total;
                gap_max  = 0;
                while (words_total < burst_at + BURST_WORDS)
                    push_good_stream();
            end
            gap_max = ($urandom_range(0, 3) == 0) ? 0 : MAX_GAP;
            if ($urandom_range(0, 3) == 0)
                push_noise_stream();
            else
                push_good_stream();
        end

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (char_q.size() != 0 || decoded_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
